// File: hw/rtl/gaussian_blur_5x5_rgb_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 5x5 Gaussian blur
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_BLUR_5X5_RGB_DEFINES_SVH
`define GAUSSIAN_BLUR_5X5_RGB_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge outside reset.
`define GB5_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gb5: same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define GB5_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gb5: next-cycle check failed");
`else
`define GB5_ASSERT_IMP(label, clk, rst, ante, cons)
`define GB5_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// File: hw/rtl/gb5_pkg.sv
// ----------------------------------------------------------------------------
// gb5_pkg
// Types, kernel taps and divider constants of the 5x5 Gaussian blur.
// ----------------------------------------------------------------------------
package gb5_pkg;

  localparam int KERNEL_SIZE   = 5;
  localparam int MAX_WIDTH_DEF = 1024;

  // Configuration port
  localparam int CFG_W_BITS    = 11;
  localparam int CFG_H_BITS    = 13;
  localparam int CFG_DATA_BITS = 13;
  localparam int CFG_IDX_BITS  = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1
  } cfg_reg_t;

  localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_H_BITS-1:0] HEIGHT_RESET = 13'd480;

  // Pixels are packed red high, blue low
  localparam int SAMPLE_BITS = 8;
  localparam int CHANNELS    = 3;
  localparam int PIX_BITS    = CHANNELS * SAMPLE_BITS;
  typedef logic [PIX_BITS-1:0] pix_t;

  // One line memory word holds the four previous rows of one column
  localparam int LINE_ROWS = KERNEL_SIZE - 1;
  localparam int LINE_BITS = LINE_ROWS * PIX_BITS;

  localparam int TAP_BITS = 6;
  typedef logic [TAP_BITS-1:0] tap_t;

  localparam tap_t TAPS [KERNEL_SIZE][KERNEL_SIZE] = '{
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd7, 6'd26, 6'd41, 6'd26, 6'd7},
    '{6'd4, 6'd16, 6'd26, 6'd16, 6'd4},
    '{6'd1, 6'd4,  6'd7,  6'd4,  6'd1}
  };

  // Row sum at most 107*255, full sum at most 273*255
  localparam int ROW_SUM_BITS = 15;
  localparam int SUM_BITS     = 17;

  // floor(s/273) == (s*DIV_RECIP) >> DIV_SHIFT for every s below 123817
  localparam int DIV_SHIFT      = 25;
  localparam int DIV_RECIP_BITS = 17;
  localparam logic [DIV_RECIP_BITS-1:0] DIV_RECIP = 17'd122911;
  localparam int PROD_BITS      = SUM_BITS + DIV_RECIP_BITS;

  // Per-slot control carried down the pipeline
  typedef struct packed {
    logic                   emit;
    logic                   eof;
    logic [KERNEL_SIZE-1:0] row_ok;
    logic [KERNEL_SIZE-1:0] col_ok;
  } slot_ctl_t;

endpackage

// File: hw/rtl/gb5_ram.sv
// ----------------------------------------------------------------------------
// gb5_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// A read of the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
module gb5_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/gaussian_blur_5x5_rgb.sv
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_rgb
// 5x5 Gaussian blur (weights summing to 273) over an RGB raster stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, red/green/blue) carries one slot per
//   word: width*height pixels in raster order, then 2*width+2 drain words
//   whose data is ignored. Output channel (out_valid/out_stall) carries one
//   blurred pixel per word; end_of_frame flags the last pixel of the frame.
//   Slot number 2*width+2 onward releases the pixel that lags by that many
//   slots. Frame size is taken from image_width/image_height at the first
//   slot of each frame; neighbors outside the frame count as zero.
//   Throughput: one slot per clock unless stalled. Each slot does one
//   read-modify-write of the line memory (one word per column, four rows
//   deep); a forwarding register covers back-to-back access to the same
//   column (width 1). After the edge that accepts the slot releasing it,
//   a result passes the line read, window, row sums, full sums, then the
//   reciprocal multiply into the output register and shows on out_valid.
//   While the receiver stalls, the output word holds and the pipeline fills
//   its bubbles; in_stall rises once the line-read stage cannot drain.
//   Reset empties the pipeline and restarts the frame; the line memory is
//   not cleared, so the input is not held off after reset.
// ----------------------------------------------------------------------------
`include "gaussian_blur_5x5_rgb_defines.svh"

module gaussian_blur_5x5_rgb
  import gb5_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_write,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  // input pixel stream
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SAMPLE_BITS-1:0]   red,
  input  logic [SAMPLE_BITS-1:0]   green,
  input  logic [SAMPLE_BITS-1:0]   blue,
  // output pixel stream
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [SAMPLE_BITS-1:0]   out_red,
  output logic [SAMPLE_BITS-1:0]   out_green,
  output logic [SAMPLE_BITS-1:0]   out_blue,
  output logic                     end_of_frame
);

  localparam int CW   = $clog2(MAX_WIDTH);         // column index
  localparam int FW   = $clog2(MAX_WIDTH + 1);     // frame width value
  localparam int LW   = $clog2(2 * MAX_WIDTH + 3); // lead count up to the lag
  localparam int HW   = CFG_H_BITS;                // row values
  localparam int WCMP = (FW > CFG_W_BITS) ? FW : CFG_W_BITS;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_W_BITS-1:0] image_width;
  logic [CFG_H_BITS-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[CFG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[CFG_H_BITS-1:0];
        default: ; // unknown index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake
  // --------------------------------------------------------------------------
  logic s1_valid, sw_pending, p1_valid, p2_valid;
  logic out_ready, p2_ready, p1_ready, sw_ready;
  logic acc, s1_adv, p1_take;

  assign out_ready = !out_valid || !out_stall;
  assign p2_ready  = !p2_valid || out_ready;
  assign p1_ready  = !p1_valid || p2_ready;
  assign sw_ready  = !sw_pending || p1_ready;
  assign in_stall  = s1_valid && !sw_ready;
  assign acc       = in_valid && !in_stall;
  assign s1_adv    = s1_valid && sw_ready;
  assign p1_take   = sw_pending && p1_ready;

  // --------------------------------------------------------------------------
  // Slot counters: input column, lead-in count, output position
  // --------------------------------------------------------------------------
  logic          frame_start;
  logic [FW-1:0] frame_w;
  logic [HW-1:0] frame_h;
  logic [CW-1:0] col;
  logic [CW-1:0] ocol;
  logic [HW-1:0] orow;
  logic [LW-1:0] lead_cnt;

  logic [WCMP-1:0] w_ext;
  logic [FW-1:0]   w_sat, eff_w;
  logic [HW-1:0]   h_sat, eff_h;
  logic [LW-1:0]   lag_eff;
  logic            emit0, eof0, col_last, ocol_last, orow_last;
  slot_ctl_t       ctl0;

  // Saturate the registers to the legal frame size
  always_comb begin
    w_ext = WCMP'(image_width);
    if (w_ext == '0) begin
      w_sat = FW'(1);
    end else if (w_ext > WCMP'(MAX_WIDTH)) begin
      w_sat = FW'(MAX_WIDTH);
    end else begin
      w_sat = FW'(w_ext);
    end
    h_sat = (image_height == '0) ? HW'(1) : image_height;
  end

  // The first slot of a frame uses the registers directly
  assign eff_w   = frame_start ? w_sat : frame_w;
  assign eff_h   = frame_start ? h_sat : frame_h;
  assign lag_eff = LW'({eff_w, 1'b0}) + LW'(2);

  assign emit0     = (lead_cnt == lag_eff);
  assign col_last  = (FW'(col) == eff_w - FW'(1));
  assign ocol_last = (FW'(ocol) == eff_w - FW'(1));
  assign orow_last = (orow == eff_h - HW'(1));
  assign eof0      = emit0 && orow_last && ocol_last;

  // Which window rows and columns fall inside the frame for this output
  always_comb begin
    ctl0.emit      = emit0;
    ctl0.eof       = eof0;
    ctl0.row_ok[0] = (orow >= HW'(2));
    ctl0.row_ok[1] = (orow >= HW'(1));
    ctl0.row_ok[2] = 1'b1;
    ctl0.row_ok[3] = ((HW + 1)'(orow) + (HW + 1)'(1)) < (HW + 1)'(eff_h);
    ctl0.row_ok[4] = ((HW + 1)'(orow) + (HW + 1)'(2)) < (HW + 1)'(eff_h);
    ctl0.col_ok[0] = (ocol >= CW'(2));
    ctl0.col_ok[1] = (ocol >= CW'(1));
    ctl0.col_ok[2] = 1'b1;
    ctl0.col_ok[3] = ((FW + 1)'(ocol) + (FW + 1)'(1)) < (FW + 1)'(eff_w);
    ctl0.col_ok[4] = ((FW + 1)'(ocol) + (FW + 1)'(2)) < (FW + 1)'(eff_w);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_start <= 1'b1;
      frame_w     <= FW'(1);
      frame_h     <= HW'(1);
      col         <= '0;
      ocol        <= '0;
      orow        <= '0;
      lead_cnt    <= '0;
    end else if (acc) begin
      if (frame_start) begin
        frame_w <= eff_w;
        frame_h <= eff_h;
      end
      frame_start <= eof0;
      if (eof0) begin
        // last output of the frame: restart everything
        col      <= '0;
        ocol     <= '0;
        orow     <= '0;
        lead_cnt <= '0;
      end else begin
        col <= col_last ? '0 : col + CW'(1);
        if (emit0) begin
          if (ocol_last) begin
            ocol <= '0;
            orow <= orow + HW'(1);
          end else begin
            ocol <= ocol + CW'(1);
          end
        end else begin
          lead_cnt <= lead_cnt + LW'(1);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: line memory read-modify-write
  // --------------------------------------------------------------------------
  logic [LINE_BITS-1:0] ram_rdata, fwd_data, col_old, ram_wdata;
  logic                 fwd_hit;
  logic [CW-1:0]        s1_addr;
  pix_t                 s1_pix;
  slot_ctl_t            s1_ctl;

  assign col_old   = fwd_hit ? fwd_data : ram_rdata;
  assign ram_wdata = {s1_pix, col_old[LINE_BITS-1:PIX_BITS]};

  gb5_ram #(
    .WIDTH (LINE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr),
    .wdata (ram_wdata),
    .re    (acc),
    .raddr (col),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
      // the write leaving stage 1 now is not yet seen by this read
      fwd_hit  <= s1_adv && (s1_addr == col);
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_addr  <= col;
      s1_pix   <= {red, green, blue};
      s1_ctl   <= ctl0;
      fwd_data <= ram_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Window: 5x5 shift register of columns, indexed [column][row]
  // --------------------------------------------------------------------------
  pix_t      win [KERNEL_SIZE][KERNEL_SIZE];
  slot_ctl_t sw_ctl;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int t = 0; t < KERNEL_SIZE - 1; t++) begin
        win[t] <= win[t + 1];
      end
      for (int s = 0; s < LINE_ROWS; s++) begin
        win[KERNEL_SIZE - 1][s] <= col_old[s * PIX_BITS +: PIX_BITS];
      end
      win[KERNEL_SIZE - 1][KERNEL_SIZE - 1] <= s1_pix;
      sw_ctl <= s1_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sw_pending <= 1'b0;
    end else if (s1_adv) begin
      sw_pending <= s1_ctl.emit;
    end else if (p1_take) begin
      sw_pending <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage P1: weighted row sums per channel
  // --------------------------------------------------------------------------
  logic [ROW_SUM_BITS-1:0] row_sum  [CHANNELS][KERNEL_SIZE];
  logic [ROW_SUM_BITS-1:0] p1_sum   [CHANNELS][KERNEL_SIZE];
  logic                    p1_eof;

  always_comb begin
    logic [SAMPLE_BITS-1:0] smp;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      for (int s = 0; s < KERNEL_SIZE; s++) begin
        row_sum[ch][s] = '0;
        for (int t = 0; t < KERNEL_SIZE; t++) begin
          smp = win[t][s][(CHANNELS - 1 - ch) * SAMPLE_BITS +: SAMPLE_BITS];
          if (sw_ctl.row_ok[s] && sw_ctl.col_ok[t]) begin
            row_sum[ch][s] = row_sum[ch][s] +
                             ROW_SUM_BITS'(TAPS[s][t]) * ROW_SUM_BITS'(smp);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (p1_ready) begin
      p1_valid <= sw_pending;
    end
  end

  always_ff @(posedge clk) begin
    if (p1_take) begin
      p1_sum <= row_sum;
      p1_eof <= sw_ctl.eof;
    end
  end

  // --------------------------------------------------------------------------
  // Stage P2: full weighted sums
  // --------------------------------------------------------------------------
  logic [SUM_BITS-1:0] full_sum [CHANNELS];
  logic [SUM_BITS-1:0] p2_sum   [CHANNELS];
  logic                p2_eof;

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      full_sum[ch] = '0;
      for (int s = 0; s < KERNEL_SIZE; s++) begin
        full_sum[ch] = full_sum[ch] + SUM_BITS'(p1_sum[ch][s]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_valid <= 1'b0;
    end else if (p2_ready) begin
      p2_valid <= p1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_ready && p1_valid) begin
      p2_sum <= full_sum;
      p2_eof <= p1_eof;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: exact divide by 273 through a reciprocal multiply
  // --------------------------------------------------------------------------
  logic [PROD_BITS-1:0] quot_prod [CHANNELS];

  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      quot_prod[ch] = PROD_BITS'(p2_sum[ch]) * PROD_BITS'(DIV_RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= p2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && p2_valid) begin
      out_red      <= quot_prod[0][DIV_SHIFT +: SAMPLE_BITS];
      out_green    <= quot_prod[1][DIV_SHIFT +: SAMPLE_BITS];
      out_blue     <= quot_prod[2][DIV_SHIFT +: SAMPLE_BITS];
      end_of_frame <= p2_eof;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Stall only comes from a blocked line-read stage
  `GB5_ASSERT_IMP(a_stall_needs_s1, clk, rst, !s1_valid, !in_stall)
  // The last output of a frame restarts the slot counters
  `GB5_ASSERT_NXT(a_eof_restarts, clk, rst, acc && eof0, frame_start && (col == '0))
  // The lead-in count never passes the lag of the latched frame
  `GB5_ASSERT_IMP(a_lead_bounded, clk, rst, !frame_start, lead_cnt <= lag_eff)
  // The input column stays inside the latched frame width
  `GB5_ASSERT_IMP(a_col_bounded, clk, rst, !frame_start, FW'(col) < frame_w)

endmodule
